>>> rtl/sra_pkg.sv
// shared types and constants for the shared relay demand aggregator
package sra_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam logic [31:0] OfflineTimeoutMs = 32'd900000;
  localparam logic [31:0] EvalPeriodMs = 32'd1000;
  localparam logic [31:0] SyncIntervalRst = 32'd60000;
  localparam logic [7:0] EmptyOffMax = 8'd255;

  typedef enum logic [1:0] {
    REQ_REGISTER   = 2'd0,
    REQ_UNREGISTER = 2'd1,
    REQ_STATUS     = 2'd2,
    REQ_TICK       = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    RELAY_OFF     = 2'd0,
    RELAY_ON      = 2'd1,
    RELAY_UNKNOWN = 2'd3
  } relay_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_ON   = 2'd1,
    CMD_OFF  = 2'd2
  } relay_cmd_e;

  typedef enum logic [1:0] {
    STS_DONE      = 2'd0,
    STS_DUP       = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_FULL      = 2'd3
  } req_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT,
    S_TICK,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    WR_NEW,
    WR_SEEN,
    WR_FLAGS,
    WR_COPY
  } wr_sel_e;

  typedef struct packed {
    logic online;
    logic demand;
    logic skip;
  } flags_t;

  typedef struct packed {
    logic [7:0]  id;
    flags_t      flags;
    logic [31:0] last_seen;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic        req_load;
    logic        rd_en;
    logic        wr_en;
    wr_sel_e     wr_sel;
    logic        cnt_inc;
    logic        cnt_dec;
    logic        acc_upd;
    logic        tick_commit;
    logic        status_we;
    req_status_e status;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    req_type_e req_type;
    logic      tick_due;
    logic      id_match;
    logic      ent_online;
    logic      hit;
    logic      cnt_zero;
    logic      cnt_full;
  } dp_sts_t;

endpackage

>>> rtl/shared_relay_demand_aggregator_unit.sv
// top level: configuration registers, controller and datapath of the relay aggregator
// one request at a time; the next transfer is taken the cycle after the result transfer
// register, status update: the table is scanned entry by entry until the id is found
// unregister: later entries are shifted down; evaluated tick: scan until a hit; early tick: no scan
// one table entry is read per cycle from the table ram
// reset (async, active low) empties the table by its fill count and sets the relay
// record to unknown; table ram contents are not cleared
module shared_relay_demand_aggregator_unit #(
  parameter int unsigned MAX_ENTRIES = sra_pkg::MaxEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  hvac_id_i,
  input  logic        online_i,
  input  logic        demand_i,
  input  logic        skips_relay_i,
  input  logic [31:0] now_ms_i,
  input  logic        relay_on_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  relay_cmd_o,
  output logic [1:0]  req_status_o,
  output logic [4:0]  entry_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sra_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic        off_when_empty_q;
  logic [31:0] sync_interval_q;
  logic        cfg_wr;

  ctl_cmd_t      cmd;
  dp_sts_t       sts;
  logic [CW-1:0] count;
  logic [AW-1:0] rd_addr, wr_addr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_when_empty_q <= 1'b0;
      sync_interval_q  <= SyncIntervalRst;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        sync_interval_q <= pwdata;
      end else begin
        off_when_empty_q <= pwdata[0];
      end
    end
  end

  assign prdata = paddr[2] ? sync_interval_q : {31'd0, off_when_empty_q};

  sra_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .count_i     (count),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr)
  );

  sra_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_type_i       (req_type_i),
    .hvac_id_i        (hvac_id_i),
    .online_i         (online_i),
    .demand_i         (demand_i),
    .skips_relay_i    (skips_relay_i),
    .now_ms_i         (now_ms_i),
    .relay_on_i       (relay_on_i),
    .off_when_empty_i (off_when_empty_q),
    .sync_interval_i  (sync_interval_q),
    .cmd_i            (cmd),
    .rd_addr_i        (rd_addr),
    .wr_addr_i        (wr_addr),
    .sts_o            (sts),
    .count_o          (count),
    .relay_cmd_o      (relay_cmd_o),
    .req_status_o     (req_status_o),
    .entry_count_o    (entry_count_o)
  );

endmodule

>>> rtl/sra_ram.sv
// generic simple dual-port ram with registered read
module sra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/sra_ctrl.sv
// controller state machine sequencing table scans, shifts and tick evaluation
module sra_ctrl #(
  parameter int unsigned MAX_ENTRIES = sra_pkg::MaxEntries,
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1),
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  sra_pkg::dp_sts_t  sts_i,
  input  logic [CW-1:0]     count_i,
  output sra_pkg::ctl_cmd_t cmd_o,
  output logic [AW-1:0]     rd_addr_o,
  output logic [AW-1:0]     wr_addr_o
);
  import sra_pkg::*;

  state_e        state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] rpos_q, rpos_d;
  logic          rv_q, rv_d;
  logic          last;
  logic [CW-1:0] rpos_prev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      rpos_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      rpos_q  <= rpos_d;
      rv_q    <= rv_d;
    end
  end

  assign last      = ((rpos_q + CW'(1)) == count_i);
  assign rpos_prev = rpos_q - CW'(1);
  assign rd_addr_o = idx_q[AW-1:0];
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_RESP);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    rpos_d    = rpos_q;
    rv_d      = 1'b0;
    cmd_o     = '0;
    wr_addr_o = rpos_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        idx_d = '0;
        if (sts_i.req_type == REQ_TICK && !sts_i.tick_due) begin
          state_d = S_RESP;
        end else if (sts_i.cnt_zero) begin
          case (sts_i.req_type)
            REQ_REGISTER: begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_sel  = WR_NEW;
              cmd_o.cnt_inc = 1'b1;
              wr_addr_o     = '0;
              state_d       = S_RESP;
            end
            REQ_TICK: begin
              state_d = S_TICK;
            end
            default: begin
              cmd_o.status_we = 1'b1;
              cmd_o.status    = STS_NOT_FOUND;
              state_d         = S_RESP;
            end
          endcase
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = (idx_q < count_i);
        if (cmd_o.rd_en) begin
          idx_d = idx_q + CW'(1);
        end
        rv_d   = cmd_o.rd_en;
        rpos_d = idx_q;
        if (rv_q) begin
          case (sts_i.req_type)
            REQ_REGISTER: begin
              if (sts_i.id_match) begin
                cmd_o.status_we = 1'b1;
                cmd_o.status    = STS_DUP;
                state_d         = S_RESP;
              end else if (last) begin
                if (sts_i.cnt_full) begin
                  cmd_o.status_we = 1'b1;
                  cmd_o.status    = STS_FULL;
                end else begin
                  cmd_o.wr_en   = 1'b1;
                  cmd_o.wr_sel  = WR_NEW;
                  cmd_o.cnt_inc = 1'b1;
                  wr_addr_o     = count_i[AW-1:0];
                end
                state_d = S_RESP;
              end
            end
            REQ_UNREGISTER: begin
              if (sts_i.id_match) begin
                if (last) begin
                  cmd_o.cnt_dec = 1'b1;
                  state_d       = S_RESP;
                end else begin
                  idx_d   = rpos_q + CW'(1);
                  rv_d    = 1'b0;
                  state_d = S_SHIFT;
                end
              end else if (last) begin
                cmd_o.status_we = 1'b1;
                cmd_o.status    = STS_NOT_FOUND;
                state_d         = S_RESP;
              end
            end
            REQ_STATUS: begin
              if (sts_i.id_match) begin
                cmd_o.wr_en  = 1'b1;
                cmd_o.wr_sel = WR_FLAGS;
                state_d      = S_RESP;
              end else if (last) begin
                cmd_o.status_we = 1'b1;
                cmd_o.status    = STS_NOT_FOUND;
                state_d         = S_RESP;
              end
            end
            default: begin
              cmd_o.wr_en   = sts_i.ent_online;
              cmd_o.wr_sel  = WR_SEEN;
              cmd_o.acc_upd = 1'b1;
              if (sts_i.hit || last) begin
                state_d = S_TICK;
              end
            end
          endcase
        end
      end
      S_SHIFT: begin
        cmd_o.rd_en = (idx_q < count_i);
        if (cmd_o.rd_en) begin
          idx_d = idx_q + CW'(1);
        end
        rv_d   = cmd_o.rd_en;
        rpos_d = idx_q;
        if (rv_q) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_COPY;
          wr_addr_o    = rpos_prev[AW-1:0];
          if (last) begin
            cmd_o.cnt_dec = 1'b1;
            state_d       = S_RESP;
          end
        end
      end
      S_TICK: begin
        cmd_o.tick_commit = 1'b1;
        state_d           = S_RESP;
      end
      S_RESP: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/sra_dp.sv
// datapath: entry table, fill count, relay bookkeeping and result registers
module sra_dp #(
  parameter int unsigned MAX_ENTRIES = sra_pkg::MaxEntries,
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1),
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        hvac_id_i,
  input  logic              online_i,
  input  logic              demand_i,
  input  logic              skips_relay_i,
  input  logic [31:0]       now_ms_i,
  input  logic              relay_on_i,
  input  logic              off_when_empty_i,
  input  logic [31:0]       sync_interval_i,
  input  sra_pkg::ctl_cmd_t cmd_i,
  input  logic [AW-1:0]     rd_addr_i,
  input  logic [AW-1:0]     wr_addr_i,
  output sra_pkg::dp_sts_t  sts_o,
  output logic [CW-1:0]     count_o,
  output logic [1:0]        relay_cmd_o,
  output logic [1:0]        req_status_o,
  output logic [4:0]        entry_count_o
);
  import sra_pkg::*;

  // latched request
  req_type_e   type_q;
  logic [7:0]  id_q;
  flags_t      flags_q;
  logic [31:0] now_q;
  logic        relay_on_q;

  logic [CW-1:0] count_q;
  logic          want_q, ignore_q;
  logic [31:0]   last_eval_q, last_sync_q, last_sync_d;
  relay_e        rec_q, rec_d, ls_q, ls_d;
  logic [7:0]    eoc_q, eoc_d;
  relay_cmd_e    res_cmd_q, tick_cmd;
  req_status_e   res_sts_q;

  entry_t        rd_ent, wr_ent;
  logic [31:0]   seen_age, eval_age, sync_age;
  logic [CW+4:0] count_ext;

  sra_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (wr_addr_i),
    .wr_data_i (wr_ent),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_addr_i),
    .rd_data_o (rd_ent)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      type_q         <= req_type_e'(req_type_i);
      id_q           <= hvac_id_i;
      flags_q.online <= online_i;
      flags_q.demand <= demand_i;
      flags_q.skip   <= skips_relay_i;
      now_q          <= now_ms_i;
      relay_on_q     <= relay_on_i;
    end
  end

  assign seen_age = now_q - rd_ent.last_seen;
  assign eval_age = now_q - last_eval_q;
  assign sync_age = now_q - last_sync_q;

  always_comb begin
    wr_ent = rd_ent;
    case (cmd_i.wr_sel)
      WR_NEW: begin
        wr_ent.id        = id_q;
        wr_ent.flags     = flags_q;
        wr_ent.last_seen = flags_q.online ? now_q : '0;
      end
      WR_SEEN:  wr_ent.last_seen = now_q;
      WR_FLAGS: wr_ent.flags = flags_q;
      default:  wr_ent = rd_ent;
    endcase
  end

  always_comb begin
    sts_o.req_type   = type_q;
    sts_o.tick_due   = (eval_age >= EvalPeriodMs);
    sts_o.id_match   = (rd_ent.id == id_q);
    sts_o.ent_online = rd_ent.flags.online;
    sts_o.hit        = !rd_ent.flags.skip && rd_ent.flags.demand &&
                       (rd_ent.flags.online || (seen_age < OfflineTimeoutMs));
    sts_o.cnt_zero   = (count_q == '0);
    sts_o.cnt_full   = (count_q == CW'(MAX_ENTRIES));
  end

  // relay decision at the end of an evaluated tick
  always_comb begin
    relay_e rec1, ls1, ls2;
    logic   sync_due;
    sync_due    = (sync_age > sync_interval_i) || (rec_q == RELAY_UNKNOWN);
    rec1        = rec_q;
    ls1         = ls_q;
    last_sync_d = last_sync_q;
    if (sync_due) begin
      if (relay_on_q) begin
        if (rec_q != RELAY_ON && ls_q != RELAY_UNKNOWN && (!ignore_q || eoc_q == '0)) begin
          ls1 = RELAY_ON;
        end
        rec1 = RELAY_ON;
      end else begin
        if (rec_q != RELAY_OFF && ls_q != RELAY_UNKNOWN) begin
          ls1 = RELAY_OFF;
        end
        rec1 = RELAY_OFF;
      end
      last_sync_d = now_q;
    end
    ls2      = ls1;
    rec_d    = rec1;
    ls_d     = ls1;
    eoc_d    = eoc_q;
    tick_cmd = CMD_NONE;
    if (!(ignore_q && (!off_when_empty_i || ({1'b0, want_q} == ls1)))) begin
      ls2  = (!ignore_q && !off_when_empty_i) ? rec1 : ls1;
      ls_d = ls2;
      if (want_q) begin
        if (ls2 != RELAY_ON) begin
          ls_d        = RELAY_ON;
          last_sync_d = now_q;
          rec_d       = RELAY_ON;
          eoc_d       = '0;
          tick_cmd    = CMD_ON;
        end
      end else begin
        if (ls2 != RELAY_OFF) begin
          ls_d        = RELAY_OFF;
          last_sync_d = now_q;
          rec_d       = RELAY_OFF;
          if (ignore_q && eoc_q != EmptyOffMax) begin
            eoc_d = eoc_q + 8'd1;
          end
          tick_cmd = CMD_OFF;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      want_q      <= 1'b0;
      ignore_q    <= 1'b1;
      last_eval_q <= '0;
      last_sync_q <= '0;
      rec_q       <= RELAY_UNKNOWN;
      ls_q        <= RELAY_UNKNOWN;
      eoc_q       <= '0;
      res_cmd_q   <= CMD_NONE;
      res_sts_q   <= STS_DONE;
    end else begin
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.req_load) begin
        want_q    <= 1'b0;
        ignore_q  <= 1'b1;
        res_cmd_q <= CMD_NONE;
        res_sts_q <= STS_DONE;
      end
      if (cmd_i.acc_upd) begin
        if (!rd_ent.flags.skip) begin
          ignore_q <= 1'b0;
        end
        if (sts_o.hit) begin
          want_q <= 1'b1;
        end
      end
      if (cmd_i.status_we) begin
        res_sts_q <= cmd_i.status;
      end
      if (cmd_i.tick_commit) begin
        last_eval_q <= now_q;
        last_sync_q <= last_sync_d;
        rec_q       <= rec_d;
        ls_q        <= ls_d;
        eoc_q       <= eoc_d;
        res_cmd_q   <= tick_cmd;
      end
    end
  end

  assign count_ext     = {5'd0, count_q};
  assign count_o       = count_q;
  assign entry_count_o = count_ext[4:0];
  assign relay_cmd_o   = res_cmd_q;
  assign req_status_o  = res_sts_q;

endmodule
